@@ rtl/rv32i_integer_execute_unit_top_macros.svh @@
// Assertion macros shared by the execute unit modules.
`ifndef RV32I_INTEGER_EXECUTE_UNIT_TOP_MACROS_SVH
`define RV32I_INTEGER_EXECUTE_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define RV32IE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define RV32IE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rv32ie_pkg.sv @@
// Types, operation codes and widths shared by the execute unit pipeline.
package rv32ie_pkg;

    localparam int XLEN    = 32;
    localparam int FUNC_W  = 5;
    localparam int IMM_W   = 21;
    localparam int SHAMT_W = 5;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 5'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB   = 5'd1;
    localparam logic [FUNC_W-1:0] FUNC_SLL   = 5'd2;
    localparam logic [FUNC_W-1:0] FUNC_SRL   = 5'd3;
    localparam logic [FUNC_W-1:0] FUNC_SRA   = 5'd4;
    localparam logic [FUNC_W-1:0] FUNC_SLT   = 5'd5;
    localparam logic [FUNC_W-1:0] FUNC_SLTU  = 5'd6;
    localparam logic [FUNC_W-1:0] FUNC_OR    = 5'd7;
    localparam logic [FUNC_W-1:0] FUNC_XOR   = 5'd8;
    localparam logic [FUNC_W-1:0] FUNC_AND   = 5'd9;
    localparam logic [FUNC_W-1:0] FUNC_LUI   = 5'd10;
    localparam logic [FUNC_W-1:0] FUNC_AUIPC = 5'd11;
    localparam logic [FUNC_W-1:0] FUNC_BEQ   = 5'd12;
    localparam logic [FUNC_W-1:0] FUNC_BNE   = 5'd13;
    localparam logic [FUNC_W-1:0] FUNC_BLT   = 5'd14;
    localparam logic [FUNC_W-1:0] FUNC_BLTU  = 5'd15;
    localparam logic [FUNC_W-1:0] FUNC_BGE   = 5'd16;
    localparam logic [FUNC_W-1:0] FUNC_BGEU  = 5'd17;
    localparam logic [FUNC_W-1:0] FUNC_JAL   = 5'd18;
    localparam logic [FUNC_W-1:0] FUNC_JALR  = 5'd19;

    // Largest positive immediates that fall just outside the branch and jal ranges.
    localparam logic [IMM_W-1:0] IMM_BRANCH_ODD_MAX = 21'h000fff;
    localparam logic [IMM_W-1:0] IMM_JAL_ODD_MAX    = 21'h0fffff;

    // One decoded instruction as it enters the pipeline.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              use_imm;
        logic [XLEN-1:0]   rs1_value;
        logic [XLEN-1:0]   rs2_value;
        logic [IMM_W-1:0]  imm;
        logic [XLEN-1:0]   pc;
    } instr_t;

    // Decode stage output: operands selected, legality resolved.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [XLEN-1:0]   op_a;
        logic [XLEN-1:0]   op_b;
        logic [XLEN-1:0]   op2;
        logic [XLEN-1:0]   imm32;
        logic [XLEN-1:0]   pc;
        logic              wr;
        logic              bad;
    } dec_t;

    // Execute stage output: raw results before the illegal mask.
    typedef struct packed {
        logic [XLEN-1:0] res;
        logic [XLEN-1:0] target;
        logic [XLEN-1:0] seq;
        logic            wr;
        logic            taken;
        logic            bad;
    } exe_t;

    // Final result beat.
    typedef struct packed {
        logic            illegal;
        logic            taken;
        logic [XLEN-1:0] next_pc;
        logic            rd_write;
        logic [XLEN-1:0] rd_value;
    } result_t;

endpackage

@@ rtl/rv32ie_decode.sv @@
// Stage 1: immediate range checks, operand selection and write classification.
`include "rv32i_integer_execute_unit_top_macros.svh"

module rv32ie_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rv32ie_pkg::instr_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rv32ie_pkg::dec_t    out_data
);

    logic             valid_reg;
    rv32ie_pkg::dec_t data_reg;
    rv32ie_pkg::dec_t data_next;
    logic             imm_i_ok;
    logic             imm_sh_ok;
    logic             imm_u_ok;
    logic             imm_b_ok;
    logic             imm_j_ok;

    // Range checks on the 21-bit signed immediate.
    always_comb begin
        imm_i_ok  = (in_data.imm[20:11] == '0) || (in_data.imm[20:11] == '1);
        imm_sh_ok = (in_data.imm[20:rv32ie_pkg::SHAMT_W] == '0);
        imm_u_ok  = !in_data.imm[20];
        imm_b_ok  = ((in_data.imm[20:12] == '0) || (in_data.imm[20:12] == '1)) &&
                    (in_data.imm != rv32ie_pkg::IMM_BRANCH_ODD_MAX);
        imm_j_ok  = (in_data.imm != rv32ie_pkg::IMM_JAL_ODD_MAX);
    end

    // Operand selection and legality per operation.
    always_comb begin
        data_next.func  = in_data.func;
        data_next.op_a  = in_data.rs1_value;
        data_next.op_b  = in_data.rs2_value;
        data_next.imm32 = {{(rv32ie_pkg::XLEN - rv32ie_pkg::IMM_W){in_data.imm[20]}},
                           in_data.imm};
        data_next.op2   = in_data.use_imm ? data_next.imm32 : in_data.rs2_value;
        data_next.pc    = in_data.pc;
        data_next.wr    = 1'b0;
        data_next.bad   = 1'b0;
        unique case (in_data.func) inside
            rv32ie_pkg::FUNC_SUB: begin
                data_next.bad = in_data.use_imm;
                data_next.wr  = 1'b1;
            end
            rv32ie_pkg::FUNC_SLL, rv32ie_pkg::FUNC_SRL, rv32ie_pkg::FUNC_SRA: begin
                data_next.bad = in_data.use_imm && !imm_sh_ok;
                data_next.wr  = 1'b1;
            end
            rv32ie_pkg::FUNC_ADD, rv32ie_pkg::FUNC_SLT, rv32ie_pkg::FUNC_SLTU,
            rv32ie_pkg::FUNC_OR, rv32ie_pkg::FUNC_XOR, rv32ie_pkg::FUNC_AND: begin
                data_next.bad = in_data.use_imm && !imm_i_ok;
                data_next.wr  = 1'b1;
            end
            rv32ie_pkg::FUNC_LUI, rv32ie_pkg::FUNC_AUIPC: begin
                data_next.bad = !imm_u_ok;
                data_next.wr  = 1'b1;
            end
            rv32ie_pkg::FUNC_BEQ, rv32ie_pkg::FUNC_BNE, rv32ie_pkg::FUNC_BLT,
            rv32ie_pkg::FUNC_BLTU, rv32ie_pkg::FUNC_BGE, rv32ie_pkg::FUNC_BGEU: begin
                data_next.bad = !imm_b_ok;
            end
            rv32ie_pkg::FUNC_JAL: begin
                data_next.bad = !imm_j_ok;
                data_next.wr  = 1'b1;
            end
            rv32ie_pkg::FUNC_JALR: begin
                data_next.bad = !imm_i_ok;
                data_next.wr  = 1'b1;
            end
            default: begin
                data_next.bad = 1'b1;
            end
        endcase
    end

    // Stage register; it advances whenever it is empty or downstream takes it.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // An unknown operation code must arrive downstream marked illegal.
    `RV32IE_ASSERT_NXT(a_unknown_func_bad, in_valid && in_ready && (in_data.func > rv32ie_pkg::FUNC_JALR), valid_reg && data_reg.bad, "unknown operation not flagged illegal")

endmodule

@@ rtl/rv32ie_alu.sv @@
// Stage 2: ALU operations, upper immediates, branch compare and jump targets.
`include "rv32i_integer_execute_unit_top_macros.svh"

module rv32ie_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rv32ie_pkg::dec_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rv32ie_pkg::exe_t  out_data
);

    logic                                valid_reg;
    rv32ie_pkg::exe_t                    data_reg;
    rv32ie_pkg::exe_t                    data_next;
    logic [rv32ie_pkg::SHAMT_W-1:0]      shamt;
    logic [rv32ie_pkg::XLEN-1:0]         upper;
    logic [rv32ie_pkg::XLEN-1:0]         seq;

    assign shamt = in_data.op2[rv32ie_pkg::SHAMT_W-1:0];
    assign upper = {in_data.imm32[19:0], 12'b0};
    assign seq   = in_data.pc + 32'd4;

    // Destination value, branch decision and transfer target per operation.
    always_comb begin
        data_next.seq = seq;
        data_next.wr  = in_data.wr;
        data_next.bad = in_data.bad;
        unique case (in_data.func) inside
            rv32ie_pkg::FUNC_ADD:   data_next.res = in_data.op_a + in_data.op2;
            rv32ie_pkg::FUNC_SUB:   data_next.res = in_data.op_a - in_data.op2;
            rv32ie_pkg::FUNC_SLL:   data_next.res = in_data.op_a << shamt;
            rv32ie_pkg::FUNC_SRL:   data_next.res = in_data.op_a >> shamt;
            rv32ie_pkg::FUNC_SRA:   data_next.res = $unsigned($signed(in_data.op_a) >>> shamt);
            rv32ie_pkg::FUNC_SLT:
                data_next.res = {31'b0, $signed(in_data.op_a) < $signed(in_data.op2)};
            rv32ie_pkg::FUNC_SLTU:  data_next.res = {31'b0, in_data.op_a < in_data.op2};
            rv32ie_pkg::FUNC_OR:    data_next.res = in_data.op_a | in_data.op2;
            rv32ie_pkg::FUNC_XOR:   data_next.res = in_data.op_a ^ in_data.op2;
            rv32ie_pkg::FUNC_AND:   data_next.res = in_data.op_a & in_data.op2;
            rv32ie_pkg::FUNC_LUI:   data_next.res = upper;
            rv32ie_pkg::FUNC_AUIPC: data_next.res = upper + in_data.pc;
            rv32ie_pkg::FUNC_JAL, rv32ie_pkg::FUNC_JALR: data_next.res = seq;
            default:                data_next.res = '0;
        endcase

        // Branch condition and jump decision.
        unique case (in_data.func) inside
            rv32ie_pkg::FUNC_BEQ:  data_next.taken = (in_data.op_a == in_data.op_b);
            rv32ie_pkg::FUNC_BNE:  data_next.taken = (in_data.op_a != in_data.op_b);
            rv32ie_pkg::FUNC_BLT:
                data_next.taken = $signed(in_data.op_a) < $signed(in_data.op_b);
            rv32ie_pkg::FUNC_BLTU: data_next.taken = in_data.op_a < in_data.op_b;
            rv32ie_pkg::FUNC_BGE:
                data_next.taken = !($signed(in_data.op_a) < $signed(in_data.op_b));
            rv32ie_pkg::FUNC_BGEU: data_next.taken = !(in_data.op_a < in_data.op_b);
            rv32ie_pkg::FUNC_JAL, rv32ie_pkg::FUNC_JALR: data_next.taken = 1'b1;
            default:               data_next.taken = 1'b0;
        endcase

        // jalr jumps off rs1; every other transfer is pc relative.
        data_next.target = (in_data.func == rv32ie_pkg::FUNC_JALR) ?
                           (in_data.op_a + in_data.imm32) : (in_data.pc + in_data.imm32);
    end

    // Stage register.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A jump is always taken and always writes its link address.
    `RV32IE_ASSERT_NXT(a_jump_links, in_valid && in_ready && ((in_data.func == rv32ie_pkg::FUNC_JAL) || (in_data.func == rv32ie_pkg::FUNC_JALR)), data_reg.taken && data_reg.wr && (data_reg.res == data_reg.seq), "jump did not link or take")

endmodule

@@ rtl/rv32ie_commit.sv @@
// Stage 3: applies the illegal mask, picks the next pc and holds the result beat.
`include "rv32i_integer_execute_unit_top_macros.svh"

module rv32ie_commit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rv32ie_pkg::exe_t     in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rv32ie_pkg::result_t  out_data
);

    logic                valid_reg;
    rv32ie_pkg::result_t data_reg;
    rv32ie_pkg::result_t data_next;
    logic                take;

    // An illegal item writes nothing and falls through to pc+4.
    always_comb begin
        take               = in_data.taken && !in_data.bad;
        data_next.illegal  = in_data.bad;
        data_next.taken    = take;
        data_next.next_pc  = take ? in_data.target : in_data.seq;
        data_next.rd_write = in_data.wr && !in_data.bad;
        data_next.rd_value = data_next.rd_write ? in_data.res : '0;
    end

    // Output register.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // An illegal beat carries no side effects.
    `RV32IE_ASSERT_IMP(a_illegal_quiet, valid_reg && data_reg.illegal, !data_reg.rd_write && !data_reg.taken && (data_reg.rd_value == '0), "illegal beat has side effects")
    // A masked item must have fallen through to the sequential address.
    `RV32IE_ASSERT_NXT(a_illegal_seq, in_valid && in_ready && in_data.bad, data_reg.next_pc == $past(in_data.seq), "illegal item did not fall through")

endmodule

@@ rtl/rv32i_integer_execute_unit_top.sv @@
// RV32I integer execute unit: streaming wrapper around a three-stage pipeline.
//
// Usage: each s_ beat carries one decoded instruction (operation code, operand
// values, immediate and pc); each m_ beat carries its result (destination value
// and write flag, next pc, taken flag, illegal flag). Exactly one result beat is
// produced per instruction, in order.
// Path: a beat accepted on the s_ side passes the decode, execute and commit
// registers in that order and then shows on m_tvalid, where it is taken
// when the receiver does not stall.
// Throughput: one instruction per cycle while m_tready is high; each stage
// registers one item and hands it on whenever the next stage is empty or is
// itself moving, so the pipeline keeps filling while a result waits on m_tready.
// Reset: aresetn low at a clock edge clears all stage valid bits; no results
// are pending afterward and s_tready comes up high.
// Stall: while m_tready is low the result beat holds; the stages behind it
// keep accepting until they are all full, then s_tready drops. Nothing is
// lost or repeated.
module rv32i_integer_execute_unit_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[4:0], use_imm[5], rs1_value[37:6], rs2_value[69:38], imm[90:70],
    // pc[122:91], zero fill above.
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rd_value[31:0], rd_write[32], next_pc[64:33], taken[65], illegal[66],
    // zero fill above.
    output logic [71:0]  m_tdata
);

    rv32ie_pkg::instr_t  instr;
    rv32ie_pkg::dec_t    dec_data;
    rv32ie_pkg::exe_t    exe_data;
    rv32ie_pkg::result_t res_data;
    logic                dec_valid;
    logic                dec_ready;
    logic                exe_valid;
    logic                exe_ready;

    // Unpack the input beat.
    assign instr.func      = s_tdata[4:0];
    assign instr.use_imm   = s_tdata[5];
    assign instr.rs1_value = s_tdata[37:6];
    assign instr.rs2_value = s_tdata[69:38];
    assign instr.imm       = s_tdata[90:70];
    assign instr.pc        = s_tdata[122:91];

    rv32ie_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (instr),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    rv32ie_alu u_alu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (exe_valid),
        .out_ready (exe_ready),
        .out_data  (exe_data)
    );

    rv32ie_commit u_commit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (exe_valid),
        .in_ready  (exe_ready),
        .in_data   (exe_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    // Pack the result beat.
    assign m_tdata = {5'b0, res_data.illegal, res_data.taken, res_data.next_pc,
                      res_data.rd_write, res_data.rd_value};

endmodule
